>>> hw/rtl/sd_spi_host_engine_macros.svh
// ---------------------------------------------------------------------------
// sd_spi_host_engine_macros
// assertion macros for the sd spi host engine
// ---------------------------------------------------------------------------
`ifndef SD_SPI_HOST_ENGINE_MACROS_SVH
`define SD_SPI_HOST_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define SSH_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define SSH_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define SSH_ASSERT_IMP(label, clk, rst, a, c)
`define SSH_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

>>> hw/rtl/ssh_pkg.sv
// ---------------------------------------------------------------------------
// ssh_pkg
// shared types and constants of the sd spi host engine
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ssh_pkg;
   localparam int SECTOR_BYTES = 512;
   localparam int WAKE_BYTES   = 10;
   localparam int BUF_AW       = $clog2(SECTOR_BYTES);

   localparam logic [2:0] OP_INIT  = 3'd0;
   localparam logic [2:0] OP_READ  = 3'd1;
   localparam logic [2:0] OP_WRITE = 3'd2;
   localparam logic [2:0] OP_RX    = 3'd3;
   localparam logic [2:0] OP_LOAD  = 3'd4;

   localparam logic [3:0] ST_OK       = 4'd0;
   localparam logic [3:0] ST_OFFSET   = 4'd1;
   localparam logic [3:0] ST_CMD_REJ  = 4'd2;
   localparam logic [3:0] ST_TOKEN    = 4'd3;
   localparam logic [3:0] ST_WR_REJ   = 4'd4;
   localparam logic [3:0] ST_CARD     = 4'd5;
   localparam logic [3:0] ST_IF_CHECK = 4'd6;
   localparam logic [3:0] ST_VOLTAGE  = 4'd7;
   localparam logic [3:0] ST_ACMD     = 4'd8;

   localparam logic [5:0] CMD0  = 6'd0;
   localparam logic [5:0] CMD8  = 6'd8;
   localparam logic [5:0] CMD13 = 6'd13;
   localparam logic [5:0] CMD17 = 6'd17;
   localparam logic [5:0] CMD24 = 6'd24;
   localparam logic [5:0] CMD41 = 6'd41;
   localparam logic [5:0] CMD55 = 6'd55;
   localparam logic [5:0] CMD58 = 6'd58;

   typedef enum logic [11:0] {
      PH_IDLE   = 12'b000000000001,
      PH_WAKE   = 12'b000000000010,
      PH_CMD    = 12'b000000000100,
      PH_R1     = 12'b000000001000,
      PH_R32    = 12'b000000010000,
      PH_TOKEN  = 12'b000000100000,
      PH_RDATA  = 12'b000001000000,
      PH_RCRC   = 12'b000010000000,
      PH_WBUSY1 = 12'b000100000000,
      PH_WDATA  = 12'b001000000000,
      PH_WBUSY2 = 12'b010000000000,
      PH_STAT2  = 12'b100000000000
   } phase_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] lba;
      logic [9:0]  offset;
      logic [7:0]  rx_byte;
      logic [8:0]  buf_index;
      logic [7:0]  buf_value;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_valid;
      logic       chip_select;
      logic [7:0] data_byte;
      logic       data_valid;
      logic       done_res;
      logic [3:0] status;
   } rsp_type;

   // sd crc7 over a command frame, x^7 + x^3 + 1
   function automatic logic [6:0] crc7(input logic [39:0] frame);
      logic [6:0] crc;
      logic       fb;
      crc = '0;
      for (int b = 39; b >= 0; b--) begin
         fb  = crc[6] ^ frame[b];
         crc = {crc[5:0], 1'b0};
         if (fb) crc = crc ^ 7'h09;
      end
      return crc;
   endfunction
endpackage
`default_nettype wire

>>> hw/rtl/ssh_stream_if.sv
// ---------------------------------------------------------------------------
// ssh_stream_if
// valid / ready channel carrying one beat of payload
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface ssh_req_if;
   logic             valid;
   logic             ready;
   ssh_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ssh_rsp_if;
   logic             valid;
   logic             ready;
   ssh_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/ssh_ram.sv
// ---------------------------------------------------------------------------
// ssh_ram
// generic single port write, single port registered read memory
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ssh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

>>> hw/rtl/ssh_sequencer.sv
// ---------------------------------------------------------------------------
// ssh_sequencer
// per-beat sequencing of init, read and write exchanges
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sd_spi_host_engine_macros.svh"
module ssh_sequencer (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      step,
   input  wire ssh_pkg::req_type          req,
   output logic                           buf_rd_en,
   output logic [ssh_pkg::BUF_AW-1:0]     buf_rd_addr,
   output logic                           rsp_fire,
   output ssh_pkg::rsp_type               rsp
);
   ssh_pkg::phase_type phase_ff, phase_in;
   logic [9:0]  count_ff, count_in;
   logic [39:0] frame_ff, frame_in;
   logic [6:0]  crc_ff, crc_in;
   logic [31:0] shift_ff, shift_in;
   logic [8:0]  offset_ff, offset_in;

   logic [5:0]  cmd;
   logic [31:0] shifted;
   ssh_pkg::rsp_type r;
   logic        emit_ok;

   assign cmd     = frame_ff[37:32];
   assign shifted = {shift_ff[23:0], req.rx_byte};

   // sector buffer fetch for the write data beat being stepped
   assign buf_rd_en   = step && req.op == ssh_pkg::OP_RX && phase_ff == ssh_pkg::PH_WDATA
                        && count_ff < 10'(ssh_pkg::SECTOR_BYTES);
   assign buf_rd_addr = count_ff[ssh_pkg::BUF_AW-1:0];

   // next state and result of one beat
   always_comb begin
      phase_in = phase_ff; count_in = count_ff; frame_in = frame_ff; crc_in = crc_ff;
      shift_in = shift_ff; offset_in = offset_ff;
      r = '0; emit_ok = 1'b0;

      // shared helpers written inline
      if (step) begin
         if (req.op <= ssh_pkg::OP_WRITE && phase_ff == ssh_pkg::PH_IDLE) begin
            emit_ok = 1'b1;
            if (req.op == ssh_pkg::OP_INIT) begin
               phase_in = ssh_pkg::PH_WAKE; count_in = 10'd1;
               r.tx_byte = 8'hFF; r.tx_valid = 1'b1;
            end else if (req.op == ssh_pkg::OP_READ && req.offset >= 10'(ssh_pkg::SECTOR_BYTES)) begin
               r.done_res = 1'b1; r.status = ssh_pkg::ST_OFFSET;
            end else begin
               offset_in = (req.op == ssh_pkg::OP_READ) ? req.offset[8:0] : offset_ff;
               frame_in  = {2'b01, (req.op == ssh_pkg::OP_READ) ? ssh_pkg::CMD17 : ssh_pkg::CMD24,
                            req.lba};
               phase_in  = ssh_pkg::PH_CMD; count_in = '0;
               r.tx_byte = frame_in[39:32]; r.tx_valid = 1'b1; r.chip_select = 1'b1;
            end
         end else if (req.op == ssh_pkg::OP_RX && phase_ff != ssh_pkg::PH_IDLE) begin
            emit_ok = 1'b1;
            r.tx_byte = 8'hFF; r.tx_valid = 1'b1; r.chip_select = 1'b1;
            unique case (phase_ff)
               ssh_pkg::PH_WAKE: begin
                  if (count_ff < 10'(ssh_pkg::WAKE_BYTES)) begin
                     count_in = count_ff + 10'd1; r.chip_select = 1'b0;
                  end else begin
                     frame_in = {2'b01, ssh_pkg::CMD0, 32'd0};
                     phase_in = ssh_pkg::PH_CMD; count_in = '0; r.tx_byte = frame_in[39:32];
                  end
               end
               ssh_pkg::PH_CMD: begin
                  if (count_ff < 10'd5) begin
                     count_in = count_ff + 10'd1;
                     case (count_ff[2:0])
                        3'd0: r.tx_byte = frame_ff[31:24];
                        3'd1: r.tx_byte = frame_ff[23:16];
                        3'd2: r.tx_byte = frame_ff[15:8];
                        3'd3: r.tx_byte = frame_ff[7:0];
                        default: r.tx_byte = {crc_ff, 1'b1};
                     endcase
                  end else begin
                     phase_in = ssh_pkg::PH_R1; count_in = '0;
                  end
               end
               ssh_pkg::PH_R1: begin
                  count_in = '0;
                  if (req.rx_byte != 8'hFF) begin
                     case (cmd)
                        ssh_pkg::CMD0: if (req.rx_byte == 8'd1)
                           frame_in = {2'b01, ssh_pkg::CMD8, 32'h000001AA};
                           else r = '0;
                        ssh_pkg::CMD8: if (req.rx_byte == 8'd1) begin
                           shift_in = '0; phase_in = ssh_pkg::PH_R32;
                        end else r = '0;
                        ssh_pkg::CMD58: if (req.rx_byte < 8'd2) begin
                           shift_in = '0; phase_in = ssh_pkg::PH_R32;
                        end else r = '0;
                        ssh_pkg::CMD55: if (req.rx_byte < 8'd2)
                           frame_in = {2'b01, ssh_pkg::CMD41, 32'h40000000};
                           else r = '0;
                        ssh_pkg::CMD41: if (req.rx_byte != 8'd0)
                           frame_in = {2'b01, ssh_pkg::CMD55, 32'd0};
                           else r = '0;
                        ssh_pkg::CMD17: if (req.rx_byte == 8'd0) phase_in = ssh_pkg::PH_TOKEN;
                           else r = '0;
                        ssh_pkg::CMD24: if (req.rx_byte == 8'd0) phase_in = ssh_pkg::PH_WBUSY1;
                           else r = '0;
                        ssh_pkg::CMD13: begin
                           shift_in = {24'd0, req.rx_byte}; phase_in = ssh_pkg::PH_STAT2;
                        end
                        default: r = '0;
                     endcase
                     if (!r.tx_valid) begin
                        phase_in = ssh_pkg::PH_IDLE; r.done_res = 1'b1;
                        case (cmd)
                           ssh_pkg::CMD8:  r.status = ssh_pkg::ST_IF_CHECK;
                           ssh_pkg::CMD58: r.status = ssh_pkg::ST_VOLTAGE;
                           ssh_pkg::CMD55: r.status = ssh_pkg::ST_ACMD;
                           ssh_pkg::CMD41: r.status = ssh_pkg::ST_OK;
                           default:        r.status = ssh_pkg::ST_CMD_REJ;
                        endcase
                     end else if (cmd == ssh_pkg::CMD0 || cmd == ssh_pkg::CMD55
                                  || cmd == ssh_pkg::CMD41) begin
                        phase_in = ssh_pkg::PH_CMD; r.tx_byte = frame_in[39:32];
                     end
                  end
               end
               ssh_pkg::PH_R32: begin
                  if (!(count_ff == '0 && (req.rx_byte == 8'hFF || req.rx_byte == 8'hFE))) begin
                     shift_in = shifted; count_in = count_ff + 10'd1;
                     if (count_ff >= 10'd3) begin
                        if (cmd == ssh_pkg::CMD8 ? shifted == 32'h000001AA
                            : (shifted != '0 && (shifted & 32'h00380000) == 32'h00380000)) begin
                           frame_in = {2'b01, (cmd == ssh_pkg::CMD8) ? ssh_pkg::CMD58
                                       : ssh_pkg::CMD55, 32'd0};
                           phase_in = ssh_pkg::PH_CMD; count_in = '0;
                           r.tx_byte = frame_in[39:32];
                        end else begin
                           phase_in = ssh_pkg::PH_IDLE; r = '0; r.done_res = 1'b1;
                           r.status = (cmd == ssh_pkg::CMD8) ? ssh_pkg::ST_IF_CHECK
                                      : ssh_pkg::ST_VOLTAGE;
                        end
                     end
                  end
               end
               ssh_pkg::PH_TOKEN: begin
                  count_in = '0;
                  if (req.rx_byte == 8'hFE) phase_in = ssh_pkg::PH_RDATA;
                  else if (req.rx_byte != 8'hFF) begin
                     phase_in = ssh_pkg::PH_IDLE; r = '0; r.done_res = 1'b1;
                     r.status = ssh_pkg::ST_TOKEN;
                  end
               end
               ssh_pkg::PH_RDATA: begin
                  r.data_valid = count_ff >= {1'b0, offset_ff};
                  r.data_byte  = r.data_valid ? req.rx_byte : 8'd0;
                  if (count_ff + 10'd1 >= 10'(ssh_pkg::SECTOR_BYTES)) begin
                     phase_in = ssh_pkg::PH_RCRC; count_in = '0;
                  end else count_in = count_ff + 10'd1;
               end
               ssh_pkg::PH_RCRC: begin
                  if (count_ff == '0) count_in = 10'd1;
                  else begin
                     phase_in = ssh_pkg::PH_IDLE; r = '0; r.done_res = 1'b1;
                  end
               end
               ssh_pkg::PH_WBUSY1: begin
                  count_in = '0;
                  if (req.rx_byte == 8'hFF) begin
                     phase_in = ssh_pkg::PH_WDATA; r.tx_byte = 8'hFE;
                  end
               end
               ssh_pkg::PH_WDATA: begin
                  if (count_ff >= 10'(ssh_pkg::SECTOR_BYTES + 3)) begin
                     count_in = '0;
                     if (req.rx_byte[4:0] != 5'h05) begin
                        phase_in = ssh_pkg::PH_IDLE; r = '0; r.done_res = 1'b1;
                        r.status = ssh_pkg::ST_WR_REJ;
                     end else phase_in = ssh_pkg::PH_WBUSY2;
                  end else count_in = count_ff + 10'd1;
               end
               ssh_pkg::PH_WBUSY2: begin
                  count_in = '0;
                  if (req.rx_byte == 8'hFF) begin
                     frame_in = {2'b01, ssh_pkg::CMD13, 32'd0};
                     phase_in = ssh_pkg::PH_CMD; r.tx_byte = frame_in[39:32];
                  end
               end
               ssh_pkg::PH_STAT2: begin
                  phase_in = ssh_pkg::PH_IDLE; r = '0; r.done_res = 1'b1;
                  r.status = (shifted != '0) ? ssh_pkg::ST_CARD : ssh_pkg::ST_OK;
               end
               default: begin
                  phase_in = ssh_pkg::PH_IDLE; emit_ok = 1'b0;
               end
            endcase
         end
      end
      crc_in = (frame_in != frame_ff) ? ssh_pkg::crc7(frame_in) : crc_ff;
      if (phase_in == ssh_pkg::PH_CMD && phase_ff != ssh_pkg::PH_CMD)
         crc_in = ssh_pkg::crc7(frame_in);
   end

   // result goes out in the beat's own cycle; write data byte is patched in at the output
   assign rsp_fire = emit_ok;
   assign rsp      = r;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ssh_pkg::PH_IDLE; count_ff <= '0; frame_ff <= '0; crc_ff <= '0;
         shift_ff <= '0; offset_ff <= '0;
      end else begin
         phase_ff <= phase_in; count_ff <= count_in; frame_ff <= frame_in; crc_ff <= crc_in;
         shift_ff <= shift_in; offset_ff <= offset_in;
      end
   end

   `SSH_ASSERT_IMP(a_rd_fires, clock, reset, buf_rd_en, rsp_fire && rsp.tx_valid && rsp.chip_select)
   `SSH_ASSERT_IMP(a_done_idle, clock, reset, rsp_fire && rsp.done_res,
                   phase_in == ssh_pkg::PH_IDLE)
   `SSH_ASSERT_IMP(a_excl, clock, reset, rsp_fire, !(rsp.done_res && rsp.tx_valid))
   `SSH_ASSERT_NEXT(a_idle_holds, clock, reset, phase_ff == ssh_pkg::PH_IDLE && !step,
                    phase_ff == ssh_pkg::PH_IDLE)
endmodule
`default_nettype wire

>>> hw/rtl/sd_spi_host_engine.sv
// ---------------------------------------------------------------------------
// sd_spi_host_engine
// sd card spi mode host engine, one spi byte exchange per beat
// ---------------------------------------------------------------------------
// usage: req_ carries start beats (init, read, write), card byte beats that
// return the byte of the last exchange, and buffer load beats. each start or
// card byte beat yields at most one rsp_ beat: the next byte to send with
// chip select, a delivered sector byte, or done with a status.
// each rsp_ beat is registered and presented in the cycle after its beat is accepted, write data
// beats included: the sector buffer read is issued on acceptance and its
// registered output is steered into tx_byte of the held beat.
// throughput: one beat per cycle while rsp_ is taken.
// a one-entry output register holds the result; when the receiver stalls,
// req_ready drops until the held beat is taken.
// reset: synchronous, returns to idle; the sector buffer is not cleared and
// must be loaded before a write.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sd_spi_host_engine (
   input  wire logic  clock,
   input  wire logic  reset,
   ssh_req_if.sink    req_ch,
   ssh_rsp_if.source  rsp_ch
);
   logic                       step;
   logic                       buf_wr;
   logic                       buf_rd_en;
   logic [ssh_pkg::BUF_AW-1:0] buf_rd_addr;
   logic [7:0]                 buf_rdata;
   logic                       fire;
   ssh_pkg::rsp_type           rsp;
   logic                       out_valid_ff;
   ssh_pkg::rsp_type           out_ff;
   logic                       out_buf_ff;

   // accept while the output register is free or being emptied
   assign req_ch.ready = !out_valid_ff || rsp_ch.ready;
   assign step         = req_ch.valid && req_ch.ready && req_ch.payload.op != ssh_pkg::OP_LOAD;
   assign buf_wr       = req_ch.valid && req_ch.ready && req_ch.payload.op == ssh_pkg::OP_LOAD;

   ssh_ram #(.WIDTH(8), .DEPTH(ssh_pkg::SECTOR_BYTES)) u_buf (
      .clock   (clock),
      .wr_en   (buf_wr),
      .wr_addr (req_ch.payload.buf_index),
      .wr_data (req_ch.payload.buf_value),
      .rd_en   (buf_rd_en),
      .rd_addr (buf_rd_addr),
      .rd_data (buf_rdata)
   );

   ssh_sequencer u_seq (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .req         (req_ch.payload),
      .buf_rd_en   (buf_rd_en),
      .buf_rd_addr (buf_rd_addr),
      .rsp_fire    (fire),
      .rsp         (rsp)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         if (fire) out_valid_ff <= 1'b1;
         else if (rsp_ch.ready) out_valid_ff <= 1'b0;
      end
      if (fire) begin
         out_ff     <= rsp;
         out_buf_ff <= buf_rd_en;
      end
   end

   // write data beats take their byte from the buffer read port, which holds until the next step
   always_comb begin
      rsp_ch.payload = out_ff;
      if (out_buf_ff) rsp_ch.payload.tx_byte = buf_rdata;
   end

   assign rsp_ch.valid = out_valid_ff;
endmodule
`default_nettype wire

>>> tb/sv/tb_sd_spi_host_engine.sv
// ---------------------------------------------------------------------------
// tb_sd_spi_host_engine
// self-checking bench for the sd card spi mode host engine
// ---------------------------------------------------------------------------
// a short table of directed beats runs first: idle and unused codes, buffer
// loads, bad read offsets and starts while busy. the whole write buffer is
// then loaded, and init, read and write are run against a card emulation.
// the emulation picks each returned byte from the predicted phase, mostly
// well formed with some faults mixed in. every response beat is checked
// field by field against a cycle-free predictor of the engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_sd_spi_host_engine;
   import ssh_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;
   localparam int RANDOM_ITEMS   = 700;

   logic clock;
   logic reset;

   ssh_req_if req_if ();
   ssh_rsp_if rsp_if ();

   sd_spi_host_engine dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // predicted engine state
   phase_type   eng_phase = PH_IDLE;
   logic [9:0]  eng_count = '0;
   logic [39:0] eng_frame = '0;
   logic [6:0]  eng_crc   = '0;
   logic [31:0] eng_shift = '0;
   logic [8:0]  eng_offset = '0;
   logic [7:0]  eng_buffer [SECTOR_BYTES];
   bit          eng_has;
   rsp_type     eng_out;

   rsp_type     pending_rsp [$];
   int          mismatches = 0;
   int          checked    = 0;
   int          result_items = 0;
   int          n_init = 0, n_read = 0, n_write = 0;
   int          idle_count = 0;
   bit          clean = 1'b0;
   bit          send_nogap = 1'b0;
   bit          hold_request = 1'b0;
   bit          hold_done = 1'b0;

   typedef struct {
      req_type beat;
      bit      typed;
      bit      has_rsp;
      rsp_type rsp;
   } row_type;

   row_type table_rows [$];

   function automatic bit chance(input int n);
      return $urandom_range(0, n - 1) == 0;
   endfunction

   // ---------------- predictor ----------------

   task automatic give(input logic [7:0] tx, input logic cs, input logic [7:0] d, input logic dv);
      eng_has = 1'b1;
      eng_out = '0;
      eng_out.tx_byte     = tx;
      eng_out.tx_valid    = 1'b1;
      eng_out.chip_select = cs;
      eng_out.data_byte   = dv ? d : 8'h00;
      eng_out.data_valid  = dv;
   endtask

   task automatic close_op(input logic [3:0] st);
      eng_phase = PH_IDLE;
      eng_has = 1'b1;
      eng_out = '0;
      eng_out.done_res = 1'b1;
      eng_out.status   = st;
   endtask

   function automatic logic [7:0] frame_at(input int i);
      if (i < 5) return eng_frame[8*(4-i) +: 8];
      return {eng_crc, 1'b1};
   endfunction

   task automatic send_cmd(input logic [5:0] c, input logic [31:0] arg);
      logic [6:0] acc;
      logic       fb;
      eng_frame = {2'b01, c, arg};
      acc = '0;
      for (int b = 39; b >= 0; b--) begin
         fb  = acc[6] ^ eng_frame[b];
         acc = {acc[5:0], 1'b0};
         if (fb) acc = acc ^ 7'h09;
      end
      eng_crc = acc;
      eng_phase = PH_CMD;
      eng_count = '0;
      give(frame_at(0), 1'b1, 8'h00, 1'b0);
   endtask

   task automatic poll_in(input phase_type p);
      eng_phase = p;
      eng_count = '0;
      give(8'hFF, 1'b1, 8'h00, 1'b0);
   endtask

   task automatic r1_done(input logic [7:0] r1);
      case (eng_frame[37:32])
         CMD0:  if (r1 == 8'd1) send_cmd(CMD8, 32'h1AA); else close_op(ST_CMD_REJ);
         CMD8:  if (r1 != 8'd1) close_op(ST_IF_CHECK);
                else begin eng_shift = '0; poll_in(PH_R32); end
         CMD58: if (r1 >= 8'd2) close_op(ST_VOLTAGE);
                else begin eng_shift = '0; poll_in(PH_R32); end
         CMD55: if (r1 < 8'd2) send_cmd(CMD41, 32'h4000_0000); else close_op(ST_ACMD);
         CMD41: if (r1 == 8'd0) close_op(ST_OK); else send_cmd(CMD55, 32'h0);
         CMD17: if (r1 == 8'd0) poll_in(PH_TOKEN); else close_op(ST_CMD_REJ);
         CMD24: if (r1 == 8'd0) poll_in(PH_WBUSY1); else close_op(ST_CMD_REJ);
         CMD13: begin eng_shift = {24'h0, r1}; poll_in(PH_STAT2); end
         default: close_op(ST_CMD_REJ);
      endcase
   endtask

   task automatic card_byte(input logic [7:0] rx);
      logic [9:0] k;
      k = eng_count;
      case (eng_phase)
         PH_WAKE:
            if (k < WAKE_BYTES) begin
               eng_count = k + 10'd1;
               give(8'hFF, 1'b0, 8'h00, 1'b0);
            end else send_cmd(CMD0, 32'h0);
         PH_CMD:
            if (k < 5) begin
               eng_count = k + 10'd1;
               give(frame_at(k + 1), 1'b1, 8'h00, 1'b0);
            end else poll_in(PH_R1);
         PH_R1:
            if (rx == 8'hFF) poll_in(PH_R1); else r1_done(rx);
         PH_R32:
            if (k == 0 && (rx == 8'hFF || rx == 8'hFE)) give(8'hFF, 1'b1, 8'h00, 1'b0);
            else begin
               eng_shift = {eng_shift[23:0], rx};
               eng_count = k + 10'd1;
               if (eng_count >= 4) begin
                  if (eng_frame[37:32] == CMD8) begin
                     if (eng_shift == 32'h1AA) send_cmd(CMD58, 32'h0);
                     else close_op(ST_IF_CHECK);
                  end else if (eng_shift != 0 && (eng_shift & 32'h0038_0000) == 32'h0038_0000)
                     send_cmd(CMD55, 32'h0);
                  else close_op(ST_VOLTAGE);
               end else give(8'hFF, 1'b1, 8'h00, 1'b0);
            end
         PH_TOKEN:
            if (rx == 8'hFF) poll_in(PH_TOKEN);
            else if (rx != 8'hFE) close_op(ST_TOKEN);
            else poll_in(PH_RDATA);
         PH_RDATA: begin
            if (k + 1 >= SECTOR_BYTES) begin
               eng_phase = PH_RCRC;
               eng_count = '0;
            end else eng_count = k + 10'd1;
            give(8'hFF, 1'b1, rx, k >= {1'b0, eng_offset});
         end
         PH_RCRC:
            if (k == 0) begin
               eng_count = 10'd1;
               give(8'hFF, 1'b1, 8'h00, 1'b0);
            end else close_op(ST_OK);
         PH_WBUSY1:
            if (rx != 8'hFF) poll_in(PH_WBUSY1);
            else begin
               eng_phase = PH_WDATA;
               eng_count = '0;
               give(8'hFE, 1'b1, 8'h00, 1'b0);
            end
         PH_WDATA:
            if (k >= SECTOR_BYTES + 3) begin
               if (rx[4:0] != 5'h05) close_op(ST_WR_REJ); else poll_in(PH_WBUSY2);
            end else begin
               eng_count = k + 10'd1;
               if (k < SECTOR_BYTES) give(eng_buffer[k[8:0]], 1'b1, 8'h00, 1'b0);
               else give(8'hFF, 1'b1, 8'h00, 1'b0);
            end
         PH_WBUSY2:
            if (rx != 8'hFF) poll_in(PH_WBUSY2); else send_cmd(CMD13, 32'h0);
         PH_STAT2:
            if ({eng_shift[23:0], rx} != 0) close_op(ST_CARD); else close_op(ST_OK);
         default: eng_phase = PH_IDLE;
      endcase
   endtask

   task automatic predict(input req_type r);
      eng_has = 1'b0;
      eng_out = '0;
      if (r.op == OP_LOAD) eng_buffer[r.buf_index] = r.buf_value;
      else if (r.op == OP_INIT || r.op == OP_READ || r.op == OP_WRITE) begin
         if (eng_phase == PH_IDLE) begin
            if (r.op == OP_INIT) begin
               eng_phase = PH_WAKE;
               eng_count = 10'd1;
               give(8'hFF, 1'b0, 8'h00, 1'b0);
            end else if (r.op == OP_READ) begin
               if (r.offset >= SECTOR_BYTES) close_op(ST_OFFSET);
               else begin
                  eng_offset = r.offset[8:0];
                  send_cmd(CMD17, r.lba);
               end
            end else send_cmd(CMD24, r.lba);
         end
      end else if (r.op == OP_RX && eng_phase != PH_IDLE) card_byte(r.rx_byte);
   endtask

   // ---------------- card emulation ----------------

   function automatic logic [7:0] card_reply();
      logic [7:0] any;
      logic [7:0] echo [4];
      any = 8'($urandom);
      echo = '{8'h00, 8'h00, 8'h01, 8'hAA};
      if (!clean && chance(24)) return any;
      case (eng_phase)
         PH_R1: begin
            if (chance(4)) return 8'hFF;
            case (eng_frame[37:32])
               CMD0, CMD8:   return 8'h01;
               CMD58, CMD55: return 8'($urandom_range(0, 1));
               CMD41:        return chance(2) ? 8'h00 : 8'h01;
               default:      return 8'h00;
            endcase
         end
         PH_R32: begin
            if (eng_count == 0 && chance(3)) return chance(2) ? 8'hFF : 8'hFE;
            if (eng_frame[37:32] == CMD8) return echo[eng_count[1:0]];
            if (eng_count == 1) return any | 8'h38;
            return any;
         end
         PH_TOKEN:   return chance(3) ? 8'hFF : 8'hFE;
         PH_WBUSY1,
         PH_WBUSY2:  return chance(3) ? 8'($urandom_range(0, 254)) : 8'hFF;
         PH_WDATA:   return (eng_count >= SECTOR_BYTES + 3) ? {any[7:5], 5'h05} : any;
         PH_STAT2:   return 8'h00;
         default:    return any;
      endcase
   endfunction

   function automatic req_type random_beat();
      req_type r;
      r.op        = OP_RX;
      r.lba       = $urandom;
      r.offset    = 10'($urandom);
      r.rx_byte   = 8'($urandom);
      r.buf_index = 9'($urandom);
      r.buf_value = 8'($urandom);
      return r;
   endfunction

   // ---------------- request side ----------------

   task automatic push_beat(input req_type r, input bit typed = 0, input bit has_rsp = 0,
                            input rsp_type rsp = '0);
      int gap;
      gap = send_nogap ? 0 : $urandom_range(0, 7);
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid   = 1'b1;
      req_if.payload = r;
      do @(posedge clock); while (!req_if.ready);
      predict(r);
      if (eng_has) result_items++;
      if (typed) begin
         if (has_rsp) pending_rsp.push_back(rsp);
      end else if (eng_has) pending_rsp.push_back(eng_out);
      if (result_items == 300 && !hold_done) hold_request = 1'b1;
   endtask

   task automatic drain();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic run_session(input bit do_start, input req_type s);
      req_type r;
      if (do_start) push_beat(s);
      while (eng_phase != PH_IDLE) begin
         r = random_beat();
         if (!clean && chance(25)) begin
            case ($urandom_range(0, 2))
               0: r.op = OP_LOAD;
               1: r.op = 3'($urandom_range(0, 2));
               default: r.op = 3'($urandom_range(5, 7));
            endcase
         end else r.rx_byte = card_reply();
         push_beat(r);
      end
      if (chance(4)) drain();
   endtask

   function automatic row_type mk_row(input logic [2:0] op, input logic [31:0] lba,
                                      input logic [9:0] off, input logic [7:0] rx,
                                      input logic [8:0] idx, input logic [7:0] val,
                                      input bit typed, input bit has_rsp, input rsp_type rsp);
      row_type t;
      t.beat    = '{op: op, lba: lba, offset: off, rx_byte: rx, buf_index: idx, buf_value: val};
      t.typed   = typed;
      t.has_rsp = has_rsp;
      t.rsp     = rsp;
      return t;
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // stimulus
   initial begin
      rsp_type  done_offset, wake_first, none;
      req_type  s;
      int       start_items;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      foreach (eng_buffer[i]) eng_buffer[i] = 8'h00;
      none = '0;
      done_offset = '0;
      done_offset.done_res = 1'b1;
      done_offset.status = ST_OFFSET;
      wake_first = '0;
      wake_first.tx_byte = 8'hFF;
      wake_first.tx_valid = 1'b1;

      // card bytes while idle, unused codes, loads, bad offsets, busy starts
      table_rows.push_back(mk_row(OP_RX, 0, 0, 8'h00, 0, 0, 1, 0, none));
      table_rows.push_back(mk_row(OP_RX, '1, '1, 8'hFF, '1, '1, 1, 0, none));
      table_rows.push_back(mk_row(3'd5, 0, 0, 0, 0, 0, 1, 0, none));
      table_rows.push_back(mk_row(3'd6, '1, '1, '1, '1, '1, 1, 0, none));
      table_rows.push_back(mk_row(3'd7, 0, 0, 0, 0, 0, 1, 0, none));
      table_rows.push_back(mk_row(OP_LOAD, 0, 0, 0, 9'd0, 8'hFF, 1, 0, none));
      table_rows.push_back(mk_row(OP_LOAD, 0, 0, 0, 9'd511, 8'h00, 1, 0, none));
      table_rows.push_back(mk_row(OP_READ, '1, 10'd512, 0, 0, 0, 1, 1, done_offset));
      table_rows.push_back(mk_row(OP_READ, 0, 10'd1023, 0, 0, 0, 1, 1, done_offset));
      table_rows.push_back(mk_row(OP_INIT, 0, 0, 0, 0, 0, 1, 1, wake_first));
      table_rows.push_back(mk_row(OP_WRITE, '1, 0, 0, 0, 0, 1, 0, none));
      table_rows.push_back(mk_row(OP_READ, 0, 0, 0, 0, 0, 1, 0, none));
      table_rows.push_back(mk_row(OP_INIT, 0, 0, 0, 0, 0, 1, 0, none));
      table_rows.push_back(mk_row(OP_RX, 0, 0, 8'h00, 0, 0, 0, 0, none));
      table_rows.push_back(mk_row(OP_RX, 0, 0, 8'hFF, 0, 0, 0, 0, none));

      repeat (12) @(negedge clock);
      reset = 1'b0;

      foreach (table_rows[i])
         push_beat(table_rows[i].beat, table_rows[i].typed, table_rows[i].has_rsp,
                   table_rows[i].rsp);
      n_init++;

      // fill every buffer entry before any write can read it
      for (int i = 0; i < SECTOR_BYTES; i++) begin
         s = random_beat();
         s.op = OP_LOAD;
         s.buf_index = 9'(i);
         s.buf_value = (i == 1) ? 8'h00 : (i == 2) ? 8'hFF : 8'($urandom);
         push_beat(s);
      end

      // well formed runs of every operation
      clean = 1'b1;
      s = random_beat();
      run_session(0, s);
      s.op = OP_READ; s.lba = 32'h0; s.offset = 10'd0;
      run_session(1, s); n_read++;
      s.op = OP_WRITE; s.lba = '1;
      run_session(1, s); n_write++;
      clean = 1'b0;
      drain();

      // random sessions with faults and noise
      start_items = result_items;
      while (result_items - start_items < RANDOM_ITEMS) begin
         s = random_beat();
         send_nogap = chance(5);
         case ($urandom_range(0, 7))
            0, 1: begin s.op = OP_INIT; n_init++; end
            2, 3, 4: begin
               s.op = OP_READ; n_read++;
               s.offset = chance(8) ? 10'($urandom_range(512, 1023)) :
                          chance(8) ? 10'd511 : 10'($urandom_range(0, 511));
            end
            default: begin s.op = OP_WRITE; n_write++; end
         endcase
         run_session(1, s);
      end
      send_nogap = 1'b0;
      drain();
      repeat (10) @(posedge clock);

      if (pending_rsp.size() != 0) mismatches += pending_rsp.size();
      $display("covered %0d inits, %0d reads, %0d writes; %0d response beats checked",
               n_init, n_read, n_write, checked);
      $display("%0d mismatching or unexpected beats", mismatches);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // response side: random stalls, one long hold, then check each beat
   initial begin
      int      gap;
      int      stretch;
      rsp_type want;
      rsp_type got;
      stretch = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (stretch > 0) stretch--;
         else if (chance(60)) stretch = $urandom_range(20, 60);
         gap = (stretch > 0) ? 0 : $urandom_range(0, 7);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_done = 1'b1;
            gap = LONG_HOLD;
         end
         if (gap > 0) begin
            rsp_if.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_if.ready = 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         got = rsp_if.payload;
         checked++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %p", got);
         end else begin
            want = pending_rsp.pop_front();
            if (got.tx_byte !== want.tx_byte || got.tx_valid !== want.tx_valid ||
                got.chip_select !== want.chip_select || got.data_byte !== want.data_byte ||
                got.data_valid !== want.data_valid || got.done_res !== want.done_res ||
                got.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at beat %0d: expected %p, got %p", checked, want, got);
            end
         end
         @(negedge clock);
      end
   end

   // watchdog on cycles with no beat moving
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_count <= 0;
      else if (idle_count >= WATCHDOG_LIMIT) begin
         $display("watchdog expired, %0d beats outstanding", pending_rsp.size());
         $display("TEST FAILED");
         $finish;
      end else idle_count <= idle_count + 1;
   end
endmodule
